/* design/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and types for the sliding window mean block.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int WINDOW_DEPTH = 8;

    localparam int SAMPLE_W = 16;
    localparam int MEAN_W   = 24;
    localparam int HELD_W   = 4;
    localparam int FRAC_W   = 8;

    localparam int SLOT_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int COUNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_DEPTH);
    // scaled dividend: |sum| * 2^FRAC_W
    localparam int NUM_W    = SUM_W + FRAC_W;
    localparam int STEP_W   = $clog2(NUM_W + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_DONE
    } swm_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* design/swm_ram.sv */
// ----------------------------------------------------------------------------
// swm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module swm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic                                         rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/swm_divider.sv */
// ----------------------------------------------------------------------------
// swm_divider
// Bit-serial restoring divider: signed sum * 2^FRAC_W / count, truncated
// toward zero. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module swm_divider (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [swm_pkg::SUM_W-1:0]      total,
    input  logic        [swm_pkg::COUNT_W-1:0]    divisor,
    output logic signed [swm_pkg::MEAN_W-1:0]     quotient,
    output swm_pkg::div_status_t                  status
);

    logic [swm_pkg::NUM_W-1:0]    num_reg,  num_next;
    logic [swm_pkg::COUNT_W-1:0]  rem_reg,  rem_next;
    logic [swm_pkg::COUNT_W-1:0]  den_reg;
    logic                         neg_reg;
    logic [swm_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;

    logic [swm_pkg::SUM_W-1:0]    mag;
    logic [swm_pkg::COUNT_W:0]    rem_shift;
    logic [swm_pkg::COUNT_W:0]    rem_diff;
    logic                         fits;
    logic [swm_pkg::NUM_W-1:0]    q_signed;

    assign mag = total[swm_pkg::SUM_W-1] ? swm_pkg::SUM_W'(-total) : swm_pkg::SUM_W'(total);

    // shift next dividend bit into the partial remainder
    assign rem_shift = {rem_reg, num_reg[swm_pkg::NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign fits      = (rem_shift >= {1'b0, den_reg});

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            num_next  = swm_pkg::NUM_W'(mag) << swm_pkg::FRAC_W;
            rem_next  = '0;
            step_next = swm_pkg::STEP_W'(swm_pkg::NUM_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            // quotient bits fill the dividend register from the bottom
            num_next  = {num_reg[swm_pkg::NUM_W-2:0], fits};
            rem_next  = fits ? swm_pkg::COUNT_W'(rem_diff) : swm_pkg::COUNT_W'(rem_shift);
            step_next = step_reg - 1'b1;
            if (step_reg == swm_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= divisor;
            neg_reg <= total[swm_pkg::SUM_W-1];
        end
    end

    assign q_signed    = neg_reg ? (~num_reg + 1'b1) : num_reg;
    assign quotient    = $signed(q_signed[swm_pkg::MEAN_W-1:0]);
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* design/sliding_window_mean.sv */
// ----------------------------------------------------------------------------
// sliding_window_mean
// Moving average over the last WINDOW_DEPTH signed samples, result in Q8.
// ----------------------------------------------------------------------------
//  channel  handshake                   payload
//  input    sample_valid/sample_ready   sample[15:0] signed
//  output   result_valid/result_ready   mean_q8[23:0] signed, held_count[3:0]
//
//  One transaction in flight: accept in the idle state, read the oldest sample
//  and update the sum in the read state, run the divider in the divide state
//  (NUM_W quotient bits, then done is seen), load the output register in the
//  done state, which waits while a held result is not yet taken. The divider,
//  one quotient bit per cycle, sets the rate unless the output stalls.
//  Reset clears sum, fill level and write slot; the window RAM is not cleared.
//  A stalled result sits in the output register while the next sample is taken.
// ----------------------------------------------------------------------------
module sliding_window_mean (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic signed [swm_pkg::MEAN_W-1:0]   mean_q8,
    output logic        [swm_pkg::HELD_W-1:0]   held_count
);

    swm_pkg::swm_state_t state_reg, state_next;

    logic [swm_pkg::SLOT_W-1:0]          slot_reg,  slot_next;
    logic [swm_pkg::COUNT_W-1:0]         fill_reg,  fill_next;
    logic signed [swm_pkg::SUM_W-1:0]    total_reg, total_next;
    logic signed [swm_pkg::SAMPLE_W-1:0] sample_reg;
    logic                                result_valid_reg, result_valid_next;
    logic signed [swm_pkg::MEAN_W-1:0]   mean_reg;
    logic [swm_pkg::HELD_W-1:0]          count_reg;

    logic                                accept;
    logic                                ram_wr;
    logic                                div_start;
    logic                                load_out;
    logic                                full;
    logic [swm_pkg::SAMPLE_W-1:0]        old_sample;
    logic signed [swm_pkg::SUM_W-1:0]    add_term;
    logic signed [swm_pkg::SUM_W-1:0]    drop_term;
    logic signed [swm_pkg::MEAN_W-1:0]   quotient;
    swm_pkg::div_status_t                div_st;

    assign accept = sample_valid && sample_ready;
    assign full   = (fill_reg == swm_pkg::COUNT_W'(swm_pkg::WINDOW_DEPTH));

    swm_ram #(
        .WIDTH (swm_pkg::SAMPLE_W),
        .DEPTH (swm_pkg::WINDOW_DEPTH)
    ) u_window (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (slot_reg),
        .wr_data (sample_reg),
        .rd_en   (accept),
        .rd_addr (slot_reg),
        .rd_data (old_sample)
    );

    swm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .total    (total_next),
        .divisor  (fill_next),
        .quotient (quotient),
        .status   (div_st)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swm_pkg::ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = swm_pkg::ST_READ;
                end
            end
            swm_pkg::ST_READ:
            begin
                state_next = swm_pkg::ST_DIV;
            end
            swm_pkg::ST_DIV:
            begin
                if (div_st.done)
                begin
                    state_next = swm_pkg::ST_DONE;
                end
            end
            swm_pkg::ST_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    state_next = swm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swm_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        sample_ready = 1'b0;
        ram_wr       = 1'b0;
        div_start    = 1'b0;
        load_out     = 1'b0;
        unique case (state_reg)
            swm_pkg::ST_IDLE:
            begin
                sample_ready = 1'b1;
            end
            swm_pkg::ST_READ:
            begin
                ram_wr    = 1'b1;
                div_start = 1'b1;
            end
            swm_pkg::ST_DIV:
            begin
            end
            swm_pkg::ST_DONE:
            begin
                load_out = !result_valid_reg || result_ready;
            end
            default:
            begin
            end
        endcase
    end

    // window bookkeeping, applied in the read cycle
    assign add_term  = swm_pkg::SUM_W'(sample_reg);
    assign drop_term = full ? swm_pkg::SUM_W'($signed(old_sample)) : '0;

    always_comb
    begin
        slot_next  = slot_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        if (ram_wr)
        begin
            total_next = total_reg + add_term - drop_term;
            if (!full)
            begin
                fill_next = fill_reg + 1'b1;
            end
            if (slot_reg == swm_pkg::SLOT_W'(swm_pkg::WINDOW_DEPTH - 1))
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        if (load_out)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= swm_pkg::ST_IDLE;
            slot_reg         <= '0;
            fill_reg         <= '0;
            total_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            slot_reg         <= slot_next;
            fill_reg         <= fill_next;
            total_reg        <= total_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
        end
        if (load_out)
        begin
            mean_reg  <= quotient;
            count_reg <= swm_pkg::HELD_W'(fill_reg);
        end
    end

    assign result_valid = result_valid_reg;
    assign mean_q8      = mean_reg;
    assign held_count   = count_reg;

    // never take a sample while the divider runs
    assert property (@(posedge clk) disable iff (!rst_n)
        !(sample_ready && div_st.busy))
        else $error("sample accepted while divider busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= swm_pkg::COUNT_W'(swm_pkg::WINDOW_DEPTH))
        else $error("fill level beyond window depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == swm_pkg::ST_READ))
        else $error("accepted transaction did not start the window update");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> div_st.busy && !div_st.done)
        else $error("divider did not start");

    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> div_st.done)
        else $error("result loaded before division finished");

endmodule
